// File: src/assert_macros.svh
// Assertion macros shared by the point mapper RTL.
// Depends on nothing; each user supplies clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define HPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks an implication that also holds while reset is asserted.
`define HPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/hpm_pkg.sv
// Shared widths, status codes and the divider word for the point mapper.
// Used by hpm_div_pipe and homography_point_mapper.
package hpm_pkg;

  localparam int COEF_W     = 21;
  localparam int PT_W       = 16;
  localparam int DIFF_W     = 17;
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int MAG_W      = SUM_W - 1;
  localparam int FRAC_SHIFT = 11;
  localparam int NUM_W      = MAG_W + FRAC_SHIFT + 1;
  localparam int Q_W        = 16;
  localparam int CMP_W      = MAG_W + Q_W;
  localparam int DIV_STAGES = Q_W;
  localparam int ROW_W      = 3 * COEF_W;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_MID    = 2'd1;
  localparam logic [1:0] REG_BOTTOM = 2'd2;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  // Word carried through the restoring divider stages.
  typedef struct packed {
    logic [NUM_W-1:0] rem_u;
    logic [NUM_W-1:0] rem_v;
    logic [MAG_W-1:0] den;
    logic [Q_W-1:0]   quo_u;
    logic [Q_W-1:0]   quo_v;
    logic             neg_u;
    logic             neg_v;
    logic             zero;
    logic             big_u;
    logic             big_v;
  } div_word_t;

endpackage

// File: src/hpm_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage for two numerators
// over a shared denominator. Depends on hpm_pkg.
module hpm_div_pipe import hpm_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  div_word_t             din,
  output div_word_t             dout
);

  div_word_t stg [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    div_word_t        src;
    div_word_t        res;
    logic [CMP_W-1:0] dsh;
    logic [CMP_W-1:0] ru;
    logic [CMP_W-1:0] rv;

    if (i == 0) begin : g_first
      assign src = din;
    end else begin : g_rest
      assign src = stg[i-1];
    end

    // Trial subtraction of the shifted denominator from both remainders.
    always_comb begin
      res = src;
      dsh = CMP_W'(src.den) << (DIV_STAGES - 1 - i);
      ru  = CMP_W'(src.rem_u);
      rv  = CMP_W'(src.rem_v);
      if (ru >= dsh) begin
        res.rem_u                    = NUM_W'(ru - dsh);
        res.quo_u[DIV_STAGES-1-i]    = 1'b1;
      end
      if (rv >= dsh) begin
        res.rem_v                    = NUM_W'(rv - dsh);
        res.quo_v[DIV_STAGES-1-i]    = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        stg[i] <= res;
      end
    end
  end

  assign dout = stg[DIV_STAGES-1];

endmodule

// File: src/homography_point_mapper.sv
// Top level of the homography point mapper: front arithmetic, divider and
// output register. Depends on hpm_pkg, hpm_div_pipe and assert_macros.svh.
// Usage:
//   s_axis carries one point per word: tdata holds point_x, point_y,
//   origin_x, origin_y (16-bit signed Q12.4 each, lowest bits first).
//   m_axis returns one word per point: tdata holds mapped_x, mapped_y and
//   tuser holds status (0 ok, 1 saturated, 2 zero denominator).
//   The cfg channel writes the three 63-bit coefficient rows by index
//   (0 top, 1 middle, 2 bottom); higher indexes are ignored. cfg_ready is
//   always high; write only while the pipeline is empty.
// Timing:
//   The path from the input register to m_axis_tvalid has 23 register stages.
//   One word per cycle is accepted sustained while m_axis_tready stays high; the 16
//   divider stages each resolve one quotient bit, so the depth is set by the quotient width.
// Reset:
//   rst clears all valid bits and loads the identity rows, so a point maps
//   to point minus origin.
// Stall:
//   Every stage holds while the stage after it is full and stalled; empty
//   stages still fill, so nothing is lost or repeated.
`include "assert_macros.svh"

module homography_point_mapper import hpm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // point_x, point_y, origin_x, origin_y
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,  // mapped_x, mapped_y
  output logic [1:0]        m_axis_tuser,  // status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [ROW_W-1:0]  cfg_data
);

  localparam int FRONT = 6;
  localparam int LAST  = FRONT + DIV_STAGES;

  logic [ROW_W-1:0] row_top;
  logic [ROW_W-1:0] row_mid;
  logic [ROW_W-1:0] row_bottom;

  logic [LAST:0] vld;
  logic [LAST:0] en;

  // Coefficient registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_top    <= ROW_W'(1) << (2 * COEF_W + 10);
      row_mid    <= ROW_W'(1) << (COEF_W + 10);
      row_bottom <= ROW_W'(1) << 17;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TOP:    row_top    <= cfg_data;
        REG_MID:    row_mid    <= cfg_data;
        REG_BOTTOM: row_bottom <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves.
  always_comb begin
    en[LAST] = !vld[LAST] || m_axis_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int k = 1; k <= LAST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: input register.
  logic signed [PT_W-1:0] px, py, ox, oy;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px <= s_axis_tdata[15:0];
      py <= s_axis_tdata[31:16];
      ox <= s_axis_tdata[47:32];
      oy <= s_axis_tdata[63:48];
    end
  end

  // Stage 1: offset from the origin.
  logic signed [DIFF_W-1:0] dx, dy;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx <= DIFF_W'(px) - DIFF_W'(ox);
      dy <= DIFF_W'(py) - DIFF_W'(oy);
    end
  end

  // Stage 2: the six products and the scaled offsets.
  logic signed [PROD_W-1:0]   p_ux, p_uy, p_vx, p_vy, p_wx, p_wy;
  logic signed [COEF_W+3:0]   c_u, c_v, c_w;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_ux <= dx * $signed(row_top[3*COEF_W-1:2*COEF_W]);
      p_uy <= dy * $signed(row_top[2*COEF_W-1:COEF_W]);
      p_vx <= dx * $signed(row_mid[3*COEF_W-1:2*COEF_W]);
      p_vy <= dy * $signed(row_mid[2*COEF_W-1:COEF_W]);
      p_wx <= dx * $signed(row_bottom[3*COEF_W-1:2*COEF_W]);
      p_wy <= dy * $signed(row_bottom[2*COEF_W-1:COEF_W]);
      c_u  <= {$signed(row_top[COEF_W-1:0]), 4'b0000};
      c_v  <= {$signed(row_mid[COEF_W-1:0]), 4'b0000};
      c_w  <= {$signed(row_bottom[COEF_W-1:0]), 4'b0000};
    end
  end

  // Stage 3: the three sums.
  logic signed [SUM_W-1:0] su, sv, sw;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      su <= SUM_W'(p_ux) + SUM_W'(p_uy) + SUM_W'(c_u);
      sv <= SUM_W'(p_vx) + SUM_W'(p_vy) + SUM_W'(c_v);
      sw <= SUM_W'(p_wx) + SUM_W'(p_wy) + SUM_W'(c_w);
    end
  end

  // Stage 4: magnitudes and quotient signs.
  logic [MAG_W-1:0] mag_u, mag_v, mag_w;
  logic             neg_u, neg_v, w_zero;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mag_u  <= MAG_W'(su[SUM_W-1] ? -su : su);
      mag_v  <= MAG_W'(sv[SUM_W-1] ? -sv : sv);
      mag_w  <= MAG_W'(sw[SUM_W-1] ? -sw : sw);
      neg_u  <= su[SUM_W-1] ^ sw[SUM_W-1];
      neg_v  <= sv[SUM_W-1] ^ sw[SUM_W-1];
      w_zero <= (sw == '0);
    end
  end

  // Stage 5: rounded numerators and the overflow check.
  div_word_t        div_in;
  div_word_t        div_out;
  logic [NUM_W-1:0] num_u, num_v;
  logic [CMP_W-1:0] den_top;

  always_comb begin
    num_u   = (NUM_W'(mag_u) << FRAC_SHIFT) + NUM_W'(mag_w >> 1);
    num_v   = (NUM_W'(mag_v) << FRAC_SHIFT) + NUM_W'(mag_w >> 1);
    den_top = CMP_W'(mag_w) << Q_W;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      div_in.rem_u <= num_u;
      div_in.rem_v <= num_v;
      div_in.den   <= mag_w;
      div_in.quo_u <= '0;
      div_in.quo_v <= '0;
      div_in.neg_u <= neg_u;
      div_in.neg_v <= neg_v;
      div_in.zero  <= w_zero;
      div_in.big_u <= CMP_W'(num_u) >= den_top;
      div_in.big_v <= CMP_W'(num_v) >= den_top;
    end
  end

  hpm_div_pipe u_div (
    .clk  (clk),
    .en   (en[LAST-1:FRONT]),
    .din  (div_in),
    .dout (div_out)
  );

  // Final stage: signs, saturation and status.
  localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

  logic [Q_W-1:0] res_x, res_y;
  logic           sat_x, sat_y;
  logic [Q_W-1:0] out_x, out_y;
  status_t        out_st;

  always_comb begin
    sat_x = div_out.big_u || (div_out.neg_u ? (div_out.quo_u > NEG_MAX)
                                            : (div_out.quo_u > POS_MAX));
    sat_y = div_out.big_v || (div_out.neg_v ? (div_out.quo_v > NEG_MAX)
                                            : (div_out.quo_v > POS_MAX));
    if (sat_x) res_x = div_out.neg_u ? NEG_MAX : POS_MAX;
    else       res_x = div_out.neg_u ? -div_out.quo_u : div_out.quo_u;
    if (sat_y) res_y = div_out.neg_v ? NEG_MAX : POS_MAX;
    else       res_y = div_out.neg_v ? -div_out.quo_v : div_out.quo_v;
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      if (div_out.zero) begin
        out_x  <= '0;
        out_y  <= '0;
        out_st <= ST_ZERO;
      end else begin
        out_x  <= res_x;
        out_y  <= res_y;
        out_st <= (sat_x || sat_y) ? ST_SAT : ST_OK;
      end
    end
  end

  assign m_axis_tvalid = vld[LAST];
  assign m_axis_tdata  = {out_y, out_x};
  assign m_axis_tuser  = out_st;

  // Checks.
  `HPM_ASSERT(a_zero_out, (m_axis_tvalid && m_axis_tuser == ST_ZERO) |-> (m_axis_tdata == '0),
              "zero denominator result is not zero")
  `HPM_ASSERT(a_sat_clamped, (m_axis_tvalid && m_axis_tuser == ST_SAT) |->
              (m_axis_tdata[15:0] == POS_MAX || m_axis_tdata[15:0] == NEG_MAX ||
               m_axis_tdata[31:16] == POS_MAX || m_axis_tdata[31:16] == NEG_MAX),
              "saturated result has no clamped coordinate")
  `HPM_ASSERT_ALWAYS(a_ready_flow, m_axis_tready |-> s_axis_tready,
                     "input stalled while output is taken")

endmodule
